>>> design/fblh_pkg.sv
// shared types, codes and lane constants for the five lane byte hash
package fblh_pkg;

   localparam logic [31:0] LANE_A_INIT = 32'h811c9dc5;
   localparam logic [31:0] LANE_B_INIT = 32'h12345678;
   localparam logic [31:0] LANE_C_INIT = 32'hdeadbeef;
   localparam logic [31:0] LANE_D_INIT = 32'hcafebabe;
   localparam logic [31:0] LANE_E_INIT = 32'hfeedface;
   localparam logic [31:0] FNV_PRIME   = 32'h01000193;
   localparam logic [4:0]  PHASE_LAST  = 5'd23;

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_LAST = 2'd1;
   localparam logic [1:0] KIND_EMIT = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_a;
      logic [31:0] digest_b;
      logic [31:0] digest_c;
      logic [31:0] digest_d;
      logic [31:0] digest_e;
   } rsp_type;

   typedef struct packed {
      logic absorb;
      logic finish;
   } lane_ctl_type;

endpackage

>>> design/fblh_lane_core.sv
// lane state registers and the combinational update of all five lanes
module fblh_lane_core
   import fblh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  lane_ctl_type ctl,
   input  logic [7:0]   data_byte,
   output rsp_type      digest
);

   logic [31:0] lane_a_ff, lane_b_ff, lane_c_ff, lane_d_ff, lane_e_ff;
   logic [31:0] lane_a_in, lane_b_in, lane_c_in, lane_d_in, lane_e_in;
   logic [31:0] position_ff, position_in;
   logic [4:0]  phase_ff, phase_in;

   logic [31:0] byte_w;
   logic [31:0] abs_a, abs_b, abs_c, abs_d, abs_e;
   logic [31:0] abs_position;
   logic [4:0]  abs_phase;

   always_comb begin
      byte_w       = {24'd0, data_byte};
      abs_a        = (lane_a_ff ^ byte_w) * FNV_PRIME;
      abs_b        = ((lane_b_ff ^ byte_w) * FNV_PRIME) + position_ff;
      abs_c        = ((lane_c_ff << 5) + lane_c_ff) ^ byte_w;
      abs_d        = ((lane_d_ff << 5) - lane_d_ff) + byte_w;
      abs_e        = (lane_e_ff ^ (byte_w << phase_ff)) + byte_w;
      abs_position = position_ff + 32'd1;
      // phase wraps after 23, and any stray larger value also goes back to 0
      if (phase_ff >= PHASE_LAST) begin
         abs_phase = 5'd0;
      end else begin
         abs_phase = phase_ff + 5'd1;
      end
   end

   // digest shows the lanes after the optional last byte
   always_comb begin
      if (ctl.absorb) begin
         digest = '{digest_a: abs_a, digest_b: abs_b, digest_c: abs_c,
                    digest_d: abs_d, digest_e: abs_e};
      end else begin
         digest = '{digest_a: lane_a_ff, digest_b: lane_b_ff, digest_c: lane_c_ff,
                    digest_d: lane_d_ff, digest_e: lane_e_ff};
      end
   end

   always_comb begin
      lane_a_in   = lane_a_ff;
      lane_b_in   = lane_b_ff;
      lane_c_in   = lane_c_ff;
      lane_d_in   = lane_d_ff;
      lane_e_in   = lane_e_ff;
      position_in = position_ff;
      phase_in    = phase_ff;
      if (ctl.finish) begin
         lane_a_in   = LANE_A_INIT;
         lane_b_in   = LANE_B_INIT;
         lane_c_in   = LANE_C_INIT;
         lane_d_in   = LANE_D_INIT;
         lane_e_in   = LANE_E_INIT;
         position_in = 32'd0;
         phase_in    = 5'd0;
      end else if (ctl.absorb) begin
         lane_a_in   = abs_a;
         lane_b_in   = abs_b;
         lane_c_in   = abs_c;
         lane_d_in   = abs_d;
         lane_e_in   = abs_e;
         position_in = abs_position;
         phase_in    = abs_phase;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_a_ff   <= LANE_A_INIT;
         lane_b_ff   <= LANE_B_INIT;
         lane_c_ff   <= LANE_C_INIT;
         lane_d_ff   <= LANE_D_INIT;
         lane_e_ff   <= LANE_E_INIT;
         position_ff <= 32'd0;
         phase_ff    <= 5'd0;
      end else begin
         lane_a_ff   <= lane_a_in;
         lane_b_ff   <= lane_b_in;
         lane_c_ff   <= lane_c_in;
         lane_d_ff   <= lane_d_in;
         lane_e_ff   <= lane_e_in;
         position_ff <= position_in;
         phase_ff    <= phase_in;
      end
   end

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |=> (position_ff == 32'd0) && (phase_ff == 5'd0)
                     && (lane_a_ff == LANE_A_INIT))
      else $error("lane state not reinitialised after finish");

   a_absorb_counts: assert property (@(posedge clock) disable iff (reset)
      (ctl.absorb && !ctl.finish) |=> position_ff == $past(position_ff) + 32'd1)
      else $error("byte position did not advance on absorb");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PHASE_LAST)
      else $error("shift phase out of range");

endmodule

>>> design/five_lane_byte_hash.sv
// five lane byte hash: top level with input beat register and result register
//
// req channel carries one message byte per beat (req_data.kind, req_data.data_byte):
// a data byte, a final byte followed by an emit, or a bare emit. kind 3 is dropped.
// rsp channel carries the five 32-bit lane words of a finished message.
// a request beat lands in the input register; at the edge where it is taken all five
// lanes are updated by one shift-add or constant multiply each, and on a finish the
// words go into the result register at that edge, as rsp_valid is set.
// one beat is taken every cycle unless a finish waits; lanes feed back combinationally.
// while the result register waits on a stalled receiver, data beats keep flowing;
// a finish then holds in the input register and req_ready falls until it is taken.
// reset (synchronous, active high) empties both registers and loads every lane
// with its initial constant and both position counters with zero, so an empty
// message yields the initial constants.
module five_lane_byte_hash
   import fblh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic         in_valid_ff, in_valid_in;
   req_type      in_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff;
   lane_ctl_type step;
   rsp_type      digest;
   logic         fire;
   logic         rsp_free;

   always_comb begin
      step.absorb = (in_ff.kind == KIND_DATA) || (in_ff.kind == KIND_LAST);
      step.finish = (in_ff.kind == KIND_LAST) || (in_ff.kind == KIND_EMIT);
   end

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign fire     = in_valid_ff && (!step.finish || rsp_free);
   assign req_ready = !in_valid_ff || fire;

   fblh_lane_core u_lane_core (
      .clock     (clock),
      .reset     (reset),
      .ctl       ('{absorb: fire && step.absorb, finish: fire && step.finish}),
      .data_byte (in_ff.data_byte),
      .digest    (digest)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire && step.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ff <= req_data;
      end
      if (fire && step.finish) begin
         rsp_ff <= digest;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_finish_emits: assert property (@(posedge clock) disable iff (reset)
      (fire && step.finish) |=> rsp_valid_ff)
      else $error("finish beat produced no result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(fire && step.finish && rsp_valid_ff && !rsp_ready))
      else $error("result register overwritten while stalled");

   a_data_no_result: assert property (@(posedge clock) disable iff (reset)
      (fire && !step.finish && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("data beat produced a result");

endmodule
